// ===== rtl/core/vbr_pkg.sv =====
// Shared types and constants for the vertex bounding-box recentering block.
`default_nettype none

package vbr_pkg;

    localparam int FIELD_W = 32;
    localparam int INDEX_W = 6;

    typedef struct packed {
        logic signed [FIELD_W-1:0] in_x;
        logic signed [FIELD_W-1:0] in_y;
        logic signed [FIELD_W-1:0] in_z;
        logic                      set_end;
    } t_vertex_in;

    typedef struct packed {
        logic signed [FIELD_W-1:0] out_x;
        logic signed [FIELD_W-1:0] out_y;
        logic signed [FIELD_W-1:0] out_z;
        logic signed [FIELD_W-1:0] center_x;
        logic signed [FIELD_W-1:0] center_y;
        logic signed [FIELD_W-1:0] center_z;
        logic [INDEX_W-1:0]        vertex_index;
        logic                      overflowed;
        logic                      run_end;
    } t_vertex_out;

endpackage

`default_nettype wire

// ===== rtl/core/vbr_in_if.sv =====
// Valid/ready channel that carries input vertices.
`default_nettype none

interface vbr_in_if import vbr_pkg::*; ();
    logic       valid;
    logic       ready;
    t_vertex_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/vbr_out_if.sv =====
// Valid/ready channel that carries recentered vertices.
`default_nettype none

interface vbr_out_if import vbr_pkg::*; ();
    logic        valid;
    logic        ready;
    t_vertex_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/vbr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module vbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // The read register holds its value while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/vertex_bbox_recenter.sv =====
// Top level: stores a vertex set, finds its bounding-box center and streams it recentered.
`default_nettype none

// Vertices are accepted one per cycle in the load state and written to a single vertex
// RAM while the per-axis minimum and maximum are tracked in registers. The vertex
// that carries set_end closes the set: input is then held off while the center is
// formed as floor((min + max) / 2) in S_CENTER, after which the stored vertices are
// read back through the RAM's one read port, one per cycle unless output back-pressure
// stretches the burst, and leave as vertex minus center, saturated, in load order.
// After the set_end vertex is accepted, the first result passes through S_CENTER,
// the RAM read register and the output register. Input reopens as soon as the last
// result sits in the output register. Vertices beyond MAX_VERTICES are dropped and
// reported through the overflowed field of every result of that set.
module vertex_bbox_recenter import vbr_pkg::*; #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_WIDTH  = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    vbr_in_if.sink    i_vtx,
    vbr_out_if.source o_res
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int CW = COORD_WIDTH;

    typedef logic signed [CW-1:0] t_coord;

    typedef enum logic [1:0] {
        S_LOAD,
        S_CENTER,
        S_BURST
    } t_state;

    function automatic t_coord to_coord(input logic [FIELD_W-1:0] f);
        logic [63:0] w;
        w = {32'b0, f};
        return w[CW-1:0];
    endfunction

    function automatic logic signed [FIELD_W-1:0] to_field(input t_coord v);
        logic signed [63:0] w;
        w = 64'(v);
        return w[FIELD_W-1:0];
    endfunction

    function automatic t_coord mid_of(input t_coord a, input t_coord b);
        logic signed [CW:0] s;
        s = {a[CW-1], a} + {b[CW-1], b};
        return s[CW:1];
    endfunction

    function automatic t_coord sub_sat(input t_coord a, input t_coord b);
        logic signed [CW:0] d;
        t_coord             r;
        d = {a[CW-1], a} - {b[CW-1], b};
        if (d[CW] != d[CW-1]) begin
            r = d[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end else begin
            r = d[CW-1:0];
        end
        return r;
    endfunction

    t_state          r_state;
    logic [NW-1:0]   r_count;
    logic            r_drop;
    logic [NW-1:0]   r_n;
    logic            r_ovf;
    logic [AW-1:0]   r_rd_addr;
    logic            r_rd_more;
    logic            r_pend;
    logic [AW-1:0]   r_pend_idx;
    logic            r_pend_last;
    logic            r_out_valid;
    t_vertex_out     r_out;

    t_coord r_min_x, r_max_x, r_min_y, r_max_y, r_min_z, r_max_z;
    t_coord r_cx, r_cy, r_cz;

    t_coord          w_x, w_y, w_z;
    logic            w_acc;
    logic            w_room;
    logic            w_first;
    logic            w_load;
    logic            w_issue;
    logic            w_issue_last;
    logic [3*CW-1:0] w_rdata;
    t_coord          w_rx, w_ry, w_rz;

    assign w_x     = to_coord(i_vtx.data.in_x);
    assign w_y     = to_coord(i_vtx.data.in_y);
    assign w_z     = to_coord(i_vtx.data.in_z);
    assign w_acc   = i_vtx.valid && i_vtx.ready;
    assign w_room  = r_count < NW'(MAX_VERTICES);
    assign w_first = (r_count == '0);

    // A read result moves into the output register when that register frees up;
    // a new read is issued only when the RAM register holds no result or its result is moving on.
    assign w_load       = r_pend && (!r_out_valid || o_res.ready);
    assign w_issue      = (r_state == S_BURST) && r_rd_more && (!r_pend || w_load);
    assign w_issue_last = ((NW+1)'(r_rd_addr) + (NW+1)'(1)) == (NW+1)'(r_n);

    assign {w_rx, w_ry, w_rz} = w_rdata;

    assign i_vtx.ready = (r_state == S_LOAD);
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    vbr_ram #(
        .WIDTH (3 * CW),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_acc && w_room),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({w_x, w_y, w_z}),
        .i_re    (w_issue),
        .i_raddr (r_rd_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_rd_more   <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (w_acc) begin
                        if (i_vtx.data.set_end) begin
                            r_n     <= w_room ? r_count + NW'(1) : r_count;
                            r_ovf   <= r_drop || !w_room;
                            r_count <= '0;
                            r_drop  <= 1'b0;
                            r_state <= S_CENTER;
                        end else if (w_room) begin
                            r_count <= r_count + NW'(1);
                        end else begin
                            r_drop <= 1'b1;
                        end
                    end
                end
                S_CENTER: begin
                    r_rd_addr <= '0;
                    r_rd_more <= 1'b1;
                    r_state   <= S_BURST;
                end
                S_BURST: begin
                    if (w_load && r_pend_last) begin
                        r_state <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase

            if (w_issue) begin
                r_pend      <= 1'b1;
                r_pend_idx  <= r_rd_addr;
                r_pend_last <= w_issue_last;
                if (w_issue_last) begin
                    r_rd_more <= 1'b0;
                end else begin
                    r_rd_addr <= r_rd_addr + AW'(1);
                end
            end else if (w_load) begin
                r_pend <= 1'b0;
            end

            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_room) begin
            if (w_first || w_x < r_min_x) r_min_x <= w_x;
            if (w_first || w_x > r_max_x) r_max_x <= w_x;
            if (w_first || w_y < r_min_y) r_min_y <= w_y;
            if (w_first || w_y > r_max_y) r_max_y <= w_y;
            if (w_first || w_z < r_min_z) r_min_z <= w_z;
            if (w_first || w_z > r_max_z) r_max_z <= w_z;
        end
        if (r_state == S_CENTER) begin
            r_cx <= mid_of(r_min_x, r_max_x);
            r_cy <= mid_of(r_min_y, r_max_y);
            r_cz <= mid_of(r_min_z, r_max_z);
        end
        if (w_load) begin
            r_out.out_x        <= to_field(sub_sat(w_rx, r_cx));
            r_out.out_y        <= to_field(sub_sat(w_ry, r_cy));
            r_out.out_z        <= to_field(sub_sat(w_rz, r_cz));
            r_out.center_x     <= to_field(r_cx);
            r_out.center_y     <= to_field(r_cy);
            r_out.center_z     <= to_field(r_cz);
            r_out.vertex_index <= INDEX_W'(r_pend_idx);
            r_out.overflowed   <= r_ovf;
            r_out.run_end      <= r_pend_last;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(MAX_VERTICES))
        else $error("vertex count above capacity");

    a_set_end_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_vtx.data.set_end) |=> (r_state == S_CENTER) && (r_count == '0))
        else $error("set end did not start center computation");

    a_pend_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_BURST))
        else $error("read pending outside the burst");

    a_burst_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CENTER) |-> (r_n != '0))
        else $error("recentering burst over an empty set");

endmodule

`default_nettype wire

// ===== test/tb_vertex_bbox_recenter.sv =====
// Testbench for vertex_bbox_recenter: directed and random vertex sets checked against a predictor.
`timescale 1ns / 1ps

module tb_vertex_bbox_recenter;
    import vbr_pkg::*;

    localparam int MAX_V = 64;
    localparam int HOLD_CYCLES = 250;

    typedef logic signed [FIELD_W-1:0] t_coord;

    localparam t_coord C_MAX = 32'sh7FFF_FFFF;
    localparam t_coord C_MIN = 32'sh8000_0000;

    // One stimulus row: the vertex, and optionally its single result typed in by hand.
    typedef struct {
        t_vertex_in  v;
        bit          typed;
        t_vertex_out res;
    } t_stim_row;

    typedef struct {
        bit          typed;
        t_vertex_out res;
    } t_stim_note;

    logic i_clk;
    logic i_rst_n;

    vbr_in_if  vin ();
    vbr_out_if vout ();

    vertex_bbox_recenter u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (vin),
        .o_res   (vout)
    );

    // Predictor state: the vertices of the open set and their bounding box.
    t_coord      pts [MAX_V][3];
    t_coord      lo [3];
    t_coord      hi [3];
    int unsigned pts_n;
    bit          pts_dropped;

    t_vertex_out recentered_q [$];
    t_stim_note  row_notes [$];
    t_stim_row   dir_rows [$];

    int errors;
    int n_sets;
    int n_in;
    int n_dropped;
    int n_checked;
    int hold_left;
    bit idle_en;

    initial begin
        i_clk = 1'b0;
    end

    always #4 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic t_coord bbox_mid(t_coord a, t_coord b);
        logic signed [FIELD_W:0] s;
        s = {a[FIELD_W-1], a} + {b[FIELD_W-1], b};
        return s[FIELD_W:1];
    endfunction

    function automatic t_coord sat_diff(t_coord v, t_coord c);
        logic signed [FIELD_W:0] d;
        d = {v[FIELD_W-1], v} - {c[FIELD_W-1], c};
        if (d[FIELD_W] != d[FIELD_W-1]) begin
            return d[FIELD_W] ? C_MIN : C_MAX;
        end
        return d[FIELD_W-1:0];
    endfunction

    function automatic t_vertex_in mk_vtx(t_coord x, t_coord y, t_coord z, bit e);
        t_vertex_in v;
        v.in_x = x;
        v.in_y = y;
        v.in_z = z;
        v.set_end = e;
        return v;
    endfunction

    // A set of one vertex is centered on itself and recenters to the origin.
    function automatic t_vertex_out lone_res(t_coord x, t_coord y, t_coord z);
        t_vertex_out r;
        r = '0;
        r.center_x = x;
        r.center_y = y;
        r.center_z = z;
        r.run_end = 1'b1;
        return r;
    endfunction

    function automatic t_coord rand_coord();
        case ($urandom_range(3))
            0, 1: return t_coord'($urandom);
            2: return (t_coord'($urandom_range(0, 8000)) - 32'sd4000) <<< 12;
            default: begin
                case ($urandom_range(3))
                    0: return C_MIN;
                    1: return C_MAX;
                    2: return '0;
                    default: return -32'sd1;
                endcase
            end
        endcase
    endfunction

    function automatic t_vertex_in rand_vertex();
        return mk_vtx(rand_coord(), rand_coord(), rand_coord(), 1'b0);
    endfunction

    task automatic add_row(input t_vertex_in v, input bit typed, input t_vertex_out res);
        t_stim_row row;
        row.v = v;
        row.typed = typed;
        row.res = res;
        dir_rows.insert(dir_rows.size(), row);
    endtask

    task automatic absorb_vertex(input t_vertex_in v, input bit typed,
                                 input t_vertex_out typed_res);
        t_coord      p [3];
        t_coord      c [3];
        t_vertex_out r;
        p[0] = v.in_x;
        p[1] = v.in_y;
        p[2] = v.in_z;
        if (pts_n < MAX_V) begin
            for (int a = 0; a < 3; a++) begin
                pts[pts_n][a] = p[a];
                if (pts_n == 0 || p[a] < lo[a]) lo[a] = p[a];
                if (pts_n == 0 || p[a] > hi[a]) hi[a] = p[a];
            end
            pts_n++;
        end else begin
            pts_dropped = 1'b1;
            n_dropped++;
        end
        if (!v.set_end) return;
        n_sets++;
        if (typed) begin
            recentered_q.insert(recentered_q.size(), typed_res);
        end else begin
            for (int a = 0; a < 3; a++) c[a] = bbox_mid(lo[a], hi[a]);
            for (int i = 0; i < pts_n; i++) begin
                r.out_x = sat_diff(pts[i][0], c[0]);
                r.out_y = sat_diff(pts[i][1], c[1]);
                r.out_z = sat_diff(pts[i][2], c[2]);
                r.center_x = c[0];
                r.center_y = c[1];
                r.center_z = c[2];
                r.vertex_index = INDEX_W'(i);
                r.overflowed = pts_dropped;
                r.run_end = (i == pts_n - 1);
                recentered_q.insert(recentered_q.size(), r);
            end
        end
        pts_n = 0;
        pts_dropped = 1'b0;
        for (int a = 0; a < 3; a++) begin
            lo[a] = '0;
            hi[a] = '0;
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected 0x%08h actual 0x%08h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_stim_note  note;
        t_vertex_out want;
        t_vertex_out got;
        if (vin.valid && vin.ready) begin
            note = row_notes.pop_front();
            absorb_vertex(vin.data, note.typed, note.res);
            n_in++;
        end
        if (vout.valid && vout.ready) begin
            got = vout.data;
            if (recentered_q.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, actual %p", $time, got);
            end else begin
                want = recentered_q.pop_front();
                n_checked++;
                compare_field("out_x", want.out_x, got.out_x);
                compare_field("out_y", want.out_y, got.out_y);
                compare_field("out_z", want.out_z, got.out_z);
                compare_field("center_x", want.center_x, got.center_x);
                compare_field("center_y", want.center_y, got.center_y);
                compare_field("center_z", want.center_z, got.center_z);
                compare_field("vertex_index", 32'(want.vertex_index),
                              32'(got.vertex_index));
                compare_field("overflowed", 32'(want.overflowed), 32'(got.overflowed));
                compare_field("run_end", 32'(want.run_end), 32'(got.run_end));
            end
        end
    end

    // Receiver: random back-pressure, plus a counted hold-off on request.
    initial begin
        vout.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                vout.ready <= 1'b0;
                hold_left--;
            end else begin
                vout.ready <= !(idle_en && $urandom_range(99) < 17);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_vertex(input t_vertex_in v, input bit typed, input t_vertex_out res);
        t_stim_note note_w;
        note_w.typed = typed;
        note_w.res = res;
        while (idle_en && $urandom_range(99) < 17) begin
            vin.valid <= 1'b0;
            @(negedge i_clk);
        end
        row_notes.insert(row_notes.size(), note_w);
        vin.valid <= 1'b1;
        vin.data <= v;
        do @(posedge i_clk); while (!vin.ready);
        @(negedge i_clk);
    endtask

    task automatic send_sets(input int n_items);
        int         sent;
        int         sz;
        t_vertex_in v;
        sent = 0;
        while (sent < n_items) begin
            sz = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            for (int k = 0; k < sz; k++) begin
                v = rand_vertex();
                v.set_end = (k == sz - 1);
                send_vertex(v, 1'b0, '0);
            end
            sent += sz;
        end
    endtask

    // Returns at a rising edge once every expected result has arrived.
    task automatic drain_results();
        vin.valid <= 1'b0;
        do @(posedge i_clk); while (recentered_q.size() != 0);
    endtask

    initial begin
        t_vertex_in v;
        vin.valid = 1'b0;
        vin.data = '0;
        i_rst_n = 1'b0;
        idle_en = 1'b1;
        hold_left = 0;
        errors = 0;
        pts_n = 0;
        pts_dropped = 1'b0;

        add_row(mk_vtx(0, 0, 0, 1'b1), 1'b1, lone_res(0, 0, 0));
        add_row(mk_vtx(C_MAX, C_MIN, -1, 1'b1), 1'b1, lone_res(C_MAX, C_MIN, -1));
        add_row(mk_vtx(C_MIN, C_MAX, 1, 1'b1), 1'b1, lone_res(C_MIN, C_MAX, 1));
        // Full-range extent: the maximum vertex saturates after recentering.
        add_row(mk_vtx(C_MAX, C_MIN, C_MAX, 1'b0), 1'b0, '0);
        add_row(mk_vtx(C_MIN, C_MAX, C_MIN, 1'b1), 1'b0, '0);
        add_row(mk_vtx(C_MAX, C_MAX, 0, 1'b0), 1'b0, '0);
        add_row(mk_vtx(C_MIN, C_MIN, C_MIN, 1'b1), 1'b0, '0);
        // Odd extents on both sides of zero exercise the floor of the center.
        add_row(mk_vtx(-3, 5, 32'sh0001_8000, 1'b0), 1'b0, '0);
        add_row(mk_vtx(0, -4, 32'shFFFF_8000, 1'b1), 1'b0, '0);
        add_row(mk_vtx(10, -20, 30, 1'b0), 1'b0, '0);
        add_row(mk_vtx(-5, 7, 100, 1'b0), 1'b0, '0);
        add_row(mk_vtx(3, 3, -50, 1'b1), 1'b0, '0);
        add_row(mk_vtx(7, 7, 7, 1'b0), 1'b0, '0);
        add_row(mk_vtx(7, 7, 7, 1'b0), 1'b0, '0);
        add_row(mk_vtx(7, 7, 7, 1'b0), 1'b0, '0);
        add_row(mk_vtx(7, 8, 6, 1'b1), 1'b0, '0);
        add_row(mk_vtx(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 1'b0), 1'b0, '0);
        add_row(mk_vtx(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 1'b1), 1'b0, '0);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[r]) send_vertex(dir_rows[r].v, dir_rows[r].typed, dir_rows[r].res);
        send_sets(10);

        // Output held off while input keeps coming, so the block closes its input.
        drain_results();
        hold_left = HOLD_CYCLES;
        @(negedge i_clk);
        send_sets(6);

        drain_results();
        idle_en = 1'b0;
        @(negedge i_clk);
        send_sets(6);
        // Two vertices past capacity; the last of them carries set_end and is dropped.
        for (int k = 0; k < MAX_V + 2; k++) begin
            v = rand_vertex();
            v.set_end = (k == MAX_V + 1);
            send_vertex(v, 1'b0, '0);
        end

        drain_results();
        idle_en = 1'b1;
        @(negedge i_clk);
        send_sets(6);

        drain_results();
        repeat (16) @(posedge i_clk);

        $display("Covered %0d vertex sets from %0d input vertices (%0d dropped past capacity),",
                 n_sets, n_in, n_dropped);
        $display("with %0d recentered results checked under random and held-off back-pressure.",
                 n_checked);
        if (errors == 0 && recentered_q.size() == 0) begin
            $display("tb: success");
        end else begin
            if (recentered_q.size() != 0) begin
                $display("%0t: %0d expected results never arrived", $time, recentered_q.size());
            end
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== vertex_bbox_recenter.f =====
rtl/core/vbr_pkg.sv
rtl/core/vbr_in_if.sv
rtl/core/vbr_out_if.sv
rtl/core/vbr_ram.sv
rtl/core/vertex_bbox_recenter.sv
test/tb_vertex_bbox_recenter.sv
